>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the lidar conversion block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is asserted
`define LPC_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked property that is also checked during reset
`define LPC_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/core/lpc_pkg.sv
// ----------------------------------------------------------------------------
// lpc_pkg
// Constants, register codes, CORDIC angle table and stage types for the
// lidar polar to cartesian converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lpc_pkg;

  // Port widths
  localparam int IN_RANGE_W = 16;
  localparam int COORD_W    = 17;
  localparam int ANGLE_W    = 32;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  // Usable range bits and angle resolution
  localparam int RANGE_BITS = 16;
  localparam int ANGLE_BITS = 32;

  localparam logic [IN_RANGE_W-1:0] RANGE_MASK =
    (RANGE_BITS >= IN_RANGE_W) ? {IN_RANGE_W{1'b1}}
                               : IN_RANGE_W'((32'd1 << RANGE_BITS) - 32'd1);
  localparam logic [ANGLE_W-1:0] ANGLE_MASK =
    ~((ANGLE_W'(1) << (ANGLE_W - ANGLE_BITS)) - ANGLE_W'(1));

  // CORDIC organization
  localparam int CORDIC_ITERS    = 24;
  localparam int ITERS_PER_STAGE = 3;
  localparam int CORDIC_STAGES   = CORDIC_ITERS / ITERS_PER_STAGE;

  // Datapath widths: Q20 coordinates with guard bits, angle with headroom
  localparam int KINV_W = 30;
  localparam int XW     = IN_RANGE_W + 23;
  localparam int ZW     = ANGLE_W + 2;
  localparam int FRAC_W = 20;

  // 1/K in Q30
  localparam logic [KINV_W-1:0] KINV_Q30 = KINV_W'(652032874);

  localparam int COORD_LIMIT = 65535;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_ANGLE = 8'd0,
    REG_ANGLE_STEP  = 8'd1,
    REG_MIN_RANGE   = 8'd2,
    REG_MAX_RANGE   = 8'd3
  } cfg_reg_t;

  // atan(2^-i) in binary angle units
  localparam logic [29:0] ATAN_TAB [CORDIC_ITERS] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
    30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
    30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
    30'd166886,    30'd83443,     30'd41722,     30'd20861,
    30'd10430,     30'd5215,      30'd2608,      30'd1304,
    30'd652,       30'd326,       30'd163,       30'd81
  };

  // One CORDIC pipeline slot
  typedef struct packed {
    logic                 pv;
    logic                 last;
    logic                 flip;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cord_t;

endpackage

>>> rtl/core/lidar_polar_to_cartesian.sv
// ----------------------------------------------------------------------------
// lidar_polar_to_cartesian
// Streams lidar range samples and converts each to an x/y point in mm.
//
// Usage:
//   Input channel (in_valid / in_stall): one range sample per transaction,
//   with a scan_end flag on the last sample of a scan. The sample angle is
//   start_angle + index * angle_step; the index returns to 0 after scan_end.
//   Result channel (out_valid / out_stall): exactly one point per sample,
//   in order. Out-of-limit ranges give point_valid 0 and x = y = 0.
//   Config channel (cfg_valid / cfg_ready): cfg_ready is always high; write
//   only while no samples are in flight. Indexes above 3 are ignored.
// Pipeline:
//   Registers from input acceptance to out_valid: an input
//   register, a range times 1/K multiply stage, 8 CORDIC stages of 3
//   micro-rotations each, and the rounding / saturation output register.
//   One sample per cycle, set by the pipelined CORDIC, while out_stall is low.
// Reset (synchronous, rst_n low): pipeline empties, angle offset goes to 0,
//   registers return to their defaults (max_range 65535, others 0).
// Stall: each stage holds while the next one is full and stalled, so empty
//   stages keep filling; in_stall rises once the whole pipeline is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lidar_polar_to_cartesian (
  input  logic                                clk,
  input  logic                                rst_n,
  // input samples
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [lpc_pkg::IN_RANGE_W-1:0]      in_range_mm,
  input  logic                                in_scan_end,
  // result points
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_point_valid,
  output logic signed [lpc_pkg::COORD_W-1:0]  out_x_mm,
  output logic signed [lpc_pkg::COORD_W-1:0]  out_y_mm,
  output logic                                out_last_of_scan,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lpc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lpc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int XW = lpc_pkg::XW;
  localparam int ZW = lpc_pkg::ZW;
  localparam int NS = lpc_pkg::CORDIC_STAGES;
  localparam int IPS = lpc_pkg::ITERS_PER_STAGE;
  localparam int FW = lpc_pkg::FRAC_W;
  localparam int RW = lpc_pkg::IN_RANGE_W;
  localparam int AW = lpc_pkg::ANGLE_W;

  localparam logic signed [XW-1:0] HALF_LSB  = XW'(1) <<< (FW - 1);
  localparam logic signed [XW-1:0] Q_LIM     = XW'(lpc_pkg::COORD_LIMIT);
  localparam logic [AW-1:0]        HALF_TURN = AW'(1) << (AW - 1);

  // Round Q20 half up, optionally negated, then saturate to the coordinate range
  function automatic logic signed [lpc_pkg::COORD_W-1:0] to_mm(
    input logic signed [XW-1:0] v,
    input logic                 neg
  );
    logic signed [XW-1:0] t;
    logic signed [XW-1:0] q;
    t = neg ? (HALF_LSB - v) : (v + HALF_LSB);
    q = t >>> FW;
    if (q > Q_LIM) begin
      q = Q_LIM;
    end else if (q < -Q_LIM) begin
      q = -Q_LIM;
    end
    return q[lpc_pkg::COORD_W-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [AW-1:0] start_angle_r;
  logic [AW-1:0] angle_step_r;
  logic [RW-1:0] min_range_r;
  logic [RW-1:0] max_range_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_angle_r <= '0;
      angle_step_r  <= '0;
      min_range_r   <= '0;
      max_range_r   <= {RW{1'b1}};
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lpc_pkg::REG_START_ANGLE: start_angle_r <= cfg_wdata[AW-1:0];
        lpc_pkg::REG_ANGLE_STEP:  angle_step_r  <= cfg_wdata[AW-1:0];
        lpc_pkg::REG_MIN_RANGE:   min_range_r   <= cfg_wdata[RW-1:0];
        lpc_pkg::REG_MAX_RANGE:   max_range_r   <= cfg_wdata[RW-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage readiness (a stage moves when it is empty or the next one moves)
  // --------------------------------------------------------------------------
  logic         out_valid_r;
  logic         out_rdy;
  logic         a_vld_r;
  logic         a_rdy;
  logic         vld_r [0:NS];
  logic         rdy   [0:NS];
  lpc_pkg::cord_t st_r [0:NS];

  assign out_rdy = !out_valid_r || !out_stall;
  assign rdy[NS] = !vld_r[NS] || out_rdy;

  for (genvar k = 0; k < NS; k++) begin : g_rdy
    assign rdy[k] = !vld_r[k] || rdy[k+1];
  end

  assign a_rdy    = !a_vld_r || rdy[0];
  assign in_stall = !a_rdy;

  // --------------------------------------------------------------------------
  // Input stage: angle of this sample, range check, offset tracking
  // --------------------------------------------------------------------------
  logic          in_acc;
  logic [RW-1:0] in_r;
  logic [AW-1:0] offset_r;
  logic [AW-1:0] offset_nxt;
  logic          a_pv_r;
  logic          a_last_r;
  logic [RW-1:0] a_range_r;
  logic [AW-1:0] a_angle_r;

  assign in_acc     = in_valid && !in_stall;
  assign in_r       = in_range_mm & lpc_pkg::RANGE_MASK;
  assign offset_nxt = in_scan_end ? '0 : (offset_r + angle_step_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
      a_vld_r  <= 1'b0;
    end else begin
      if (in_acc) begin
        offset_r <= offset_nxt;
      end
      if (a_rdy) begin
        a_vld_r <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_pv_r    <= (in_r >= min_range_r) && (in_r <= max_range_r);
      a_last_r  <= in_scan_end;
      a_range_r <= in_r;
      a_angle_r <= start_angle_r + offset_r;
    end
  end

  // --------------------------------------------------------------------------
  // Prescale stage: x0 = r / K in Q20, quadrant fold of the angle
  // --------------------------------------------------------------------------
  logic [RW+lpc_pkg::KINV_W-1:0] prod;
  logic [AW-1:0]                 ang_m;
  logic [AW-1:0]                 ang_f;
  logic                          flip;
  lpc_pkg::cord_t                pre_nxt;

  always_comb begin
    prod  = a_range_r * lpc_pkg::KINV_Q30;
    ang_m = a_angle_r & lpc_pkg::ANGLE_MASK;
    flip  = ang_m[AW-1] ^ ang_m[AW-2];
    ang_f = flip ? (ang_m - HALF_TURN) : ang_m;

    pre_nxt.pv   = a_pv_r;
    pre_nxt.last = a_last_r;
    pre_nxt.flip = flip;
    pre_nxt.x    = {{(XW-RW-lpc_pkg::KINV_W+10){1'b0}}, prod[RW+lpc_pkg::KINV_W-1:10]};
    pre_nxt.y    = '0;
    pre_nxt.z    = {{(ZW-AW){ang_f[AW-1]}}, ang_f};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (rdy[0]) begin
      vld_r[0] <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && a_vld_r) begin
      st_r[0] <= pre_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // CORDIC rotation stages, IPS micro-rotations each
  // --------------------------------------------------------------------------
  for (genvar k = 1; k <= NS; k++) begin : g_cordic
    lpc_pkg::cord_t nxt;

    always_comb begin
      logic signed [XW-1:0] cx;
      logic signed [XW-1:0] cy;
      logic signed [XW-1:0] sx;
      logic signed [XW-1:0] sy;
      logic signed [ZW-1:0] cz;
      logic signed [ZW-1:0] at;
      nxt = st_r[k-1];
      cx  = st_r[k-1].x;
      cy  = st_r[k-1].y;
      cz  = st_r[k-1].z;
      for (int j = 0; j < IPS; j++) begin
        sx = cx >>> ((k - 1) * IPS + j);
        sy = cy >>> ((k - 1) * IPS + j);
        at = $signed({{(ZW-30){1'b0}}, lpc_pkg::ATAN_TAB[(k - 1) * IPS + j]});
        if (!cz[ZW-1]) begin
          cx = cx - sy;
          cy = cy + sx;
          cz = cz - at;
        end else begin
          cx = cx + sy;
          cy = cy - sx;
          cz = cz + at;
        end
      end
      nxt.x = cx;
      nxt.y = cy;
      nxt.z = cz;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && vld_r[k-1]) begin
        st_r[k] <= nxt;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register: unfold quadrant, round, saturate, blank invalid points
  // --------------------------------------------------------------------------
  logic                               pv_r;
  logic                               last_r;
  logic signed [lpc_pkg::COORD_W-1:0] x_r;
  logic signed [lpc_pkg::COORD_W-1:0] y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_rdy) begin
      out_valid_r <= vld_r[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy && vld_r[NS]) begin
      pv_r   <= st_r[NS].pv;
      last_r <= st_r[NS].last;
      x_r    <= st_r[NS].pv ? to_mm(st_r[NS].x, st_r[NS].flip) : '0;
      y_r    <= st_r[NS].pv ? to_mm(st_r[NS].y, st_r[NS].flip) : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_point_valid  = pv_r;
  assign out_last_of_scan = last_r;
  assign out_x_mm         = x_r;
  assign out_y_mm         = y_r;

endmodule

>>> rtl/core/lpc_checker.sv
// ----------------------------------------------------------------------------
// lpc_checker
// Port-level checks for the lidar polar to cartesian converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lpc_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic                                out_point_valid,
  input logic signed [lpc_pkg::COORD_W-1:0]  out_x_mm,
  input logic signed [lpc_pkg::COORD_W-1:0]  out_y_mm,
  input logic                                out_last_of_scan
);

  // Most negative 17-bit code lies outside the saturated range
  localparam logic signed [lpc_pkg::COORD_W-1:0] COORD_MIN_CODE =
    {1'b1, {(lpc_pkg::COORD_W-1){1'b0}}};

  // Pipeline is empty right after reset
  `LPC_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "out_valid after reset")

  // A rejected range carries a zero point
  `LPC_ASSERT(a_invalid_zero, clk, rst_n,
    out_valid && !out_point_valid |-> out_x_mm == '0 && out_y_mm == '0,
    "nonzero coordinates on invalid point")

  // Coordinates stay within the saturation limits
  `LPC_ASSERT(a_coord_sat, clk, rst_n,
    out_valid |-> out_x_mm != COORD_MIN_CODE && out_y_mm != COORD_MIN_CODE,
    "coordinate outside saturation range")

  // A stalled result holds its payload
  `LPC_ASSERT(a_out_hold, clk, rst_n,
    out_valid && out_stall |=> out_valid && $stable(out_x_mm) && $stable(out_y_mm)
      && $stable(out_point_valid) && $stable(out_last_of_scan),
    "stalled result changed")

endmodule

bind lidar_polar_to_cartesian lpc_checker u_lpc_checker (.*);

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// tb
// Self-checking bench for lidar_polar_to_cartesian. Range samples are fed
// from a queue by a clocked driver with random gaps. Each accepted sample is
// converted to an expected x/y point by a bit-exact CORDIC predictor in the
// bench. A clocked monitor stalls the result channel at random and checks
// every point against the oldest prediction. A directed opening runs the
// range bounds, the quadrant edges, saturation and rejected ranges. Random
// phases follow, each under a fresh register setting.
// ----------------------------------------------------------------------------
module tb;

  localparam int RST_CYCLES   = 5;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 16;
  localparam int QUIET_LIMIT  = 4000;
  localparam int RAND_PHASES  = 10;
  localparam int PHASE_ITEMS  = 155;
  localparam int MAX_REPORTS  = 10;

  // register indexes that the block must ignore
  localparam logic [lpc_pkg::CFG_IDX_W-1:0] REG_UNUSED_LO = 8'd4;
  localparam logic [lpc_pkg::CFG_IDX_W-1:0] REG_UNUSED_HI = 8'hFF;

  // 1/K in Q30, coordinate clamp, atan(2^-i) in binary angle units
  localparam longint KINV   = 64'd652032874;
  localparam longint SAT_MM = 65535;
  localparam int     ROT_STEPS = 24;
  localparam longint ROT_ANGLE [ROT_STEPS] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838,  5340245,   2670163,   1335087,  667544,   333772,
    166886,    83443,     41722,     20861,    10430,    5215,
    2608,      1304,      652,       326,      163,      81
  };

  typedef struct packed {
    logic [lpc_pkg::IN_RANGE_W-1:0] range_mm;
    logic                           scan_end;
  } sample_t;

  typedef struct packed {
    logic                               point_valid;
    logic signed [lpc_pkg::COORD_W-1:0] x_mm;
    logic signed [lpc_pkg::COORD_W-1:0] y_mm;
    logic                               last_of_scan;
  } point_t;

  logic                                clk         = 1'b0;
  logic                                rst_n       = 1'b0;
  logic                                in_valid    = 1'b0;
  wire                                 in_stall;
  logic [lpc_pkg::IN_RANGE_W-1:0]      in_range_mm = '0;
  logic                                in_scan_end = 1'b0;
  wire                                 out_valid;
  logic                                out_stall   = 1'b0;
  wire                                 out_point_valid;
  wire signed [lpc_pkg::COORD_W-1:0]   out_x_mm;
  wire signed [lpc_pkg::COORD_W-1:0]   out_y_mm;
  wire                                 out_last_of_scan;
  logic                                cfg_valid   = 1'b0;
  wire                                 cfg_ready;
  logic [lpc_pkg::CFG_IDX_W-1:0]       cfg_index   = '0;
  logic [lpc_pkg::CFG_DATA_W-1:0]      cfg_wdata   = '0;

  // shadow copy of the registers and of the scan position
  logic [31:0] start_angle_q = '0;
  logic [31:0] step_q        = '0;
  logic [31:0] offset_q      = '0;
  logic [15:0] min_q         = '0;
  logic [15:0] max_q         = 16'hFFFF;

  sample_t samples_todo[$];
  point_t  points_due[$];

  sample_t taken, next_sample;
  point_t  got, want;
  int      gap_max      = 4;
  int      stall_max    = 4;
  int      hold_req     = 0;
  int      hold_served  = 0;
  int      hold_left    = 0;
  int      send_wait    = 0;
  int      recv_wait    = 0;
  int      quiet_cycles = 0;
  int      points_seen  = 0;
  int      err_count    = 0;

  lidar_polar_to_cartesian dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_range_mm      (in_range_mm),
    .in_scan_end      (in_scan_end),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_point_valid  (out_point_valid),
    .out_x_mm         (out_x_mm),
    .out_y_mm         (out_y_mm),
    .out_last_of_scan (out_last_of_scan),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Q20 to mm: round half up, then clamp
  function automatic logic signed [lpc_pkg::COORD_W-1:0] q20_to_mm(longint q);
    longint v;
    v = (q + 64'sd524288) >>> 20;
    if (v > SAT_MM) begin
      v = SAT_MM;
    end else if (v < -SAT_MM) begin
      v = -SAT_MM;
    end
    return v[lpc_pkg::COORD_W-1:0];
  endfunction

  // Expected point for one sample at the given angle
  function automatic point_t polar_to_xy(sample_t s, logic [31:0] ang);
    point_t p;
    logic [31:0] a;
    logic flip;
    longint x, y, z, dx, dy;
    p = '0;
    p.last_of_scan = s.scan_end;
    if (s.range_mm >= min_q && s.range_mm <= max_q) begin
      // fold quadrants 1 and 2 onto 3 and 0, negate at the end
      a = ang;
      flip = (a[31:30] == 2'b01) || (a[31:30] == 2'b10);
      if (flip) begin
        a = a - 32'h8000_0000;
      end
      z = longint'($signed(a));
      x = (longint'(s.range_mm) * KINV) >>> 10;
      y = 0;
      for (int i = 0; i < ROT_STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x = x - dx;
          y = y + dy;
          z = z - ROT_ANGLE[i];
        end else begin
          x = x + dx;
          y = y - dy;
          z = z + ROT_ANGLE[i];
        end
      end
      if (flip) begin
        x = -x;
        y = -y;
      end
      p.point_valid = 1'b1;
      p.x_mm = q20_to_mm(x);
      p.y_mm = q20_to_mm(y);
    end
    return p;
  endfunction

  task automatic queue_sample(input logic [15:0] r, input logic last);
    sample_t s;
    s.range_mm = r;
    s.scan_end = last;
    samples_todo.insert(samples_todo.size(), s);
  endtask

  // one register write transaction
  task automatic write_reg(input logic [lpc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      lpc_pkg::REG_START_ANGLE: start_angle_q = data;
      lpc_pkg::REG_ANGLE_STEP:  step_q = data;
      lpc_pkg::REG_MIN_RANGE:   min_q = data[15:0];
      lpc_pkg::REG_MAX_RANGE:   max_q = data[15:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  // checked between edges so the driver's updates have all settled
  task automatic wait_idle();
    while (samples_todo.size() != 0 || in_valid || points_due.size() != 0)
      @(negedge clk);
  endtask

  // drain the pipeline, then load a full register setting
  task automatic reprogram(input logic [31:0] start, input logic [31:0] step,
                           input logic [15:0] lo, input logic [15:0] hi);
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    write_reg(lpc_pkg::REG_START_ANGLE, start);
    write_reg(lpc_pkg::REG_ANGLE_STEP, step);
    write_reg(lpc_pkg::REG_MIN_RANGE, {16'h0, lo});
    write_reg(lpc_pkg::REG_MAX_RANGE, {16'h0, hi});
  endtask

  // Sample driver: predicts on every accepted transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      offset_q = '0;
      send_wait = 0;
    end else begin
      if (in_valid && !in_stall) begin
        taken.range_mm = in_range_mm;
        taken.scan_end = in_scan_end;
        points_due.insert(points_due.size(), polar_to_xy(taken, start_angle_q + offset_q));
        offset_q = in_scan_end ? 32'h0 : offset_q + step_q;
        send_wait = $urandom_range(0, gap_max);
      end
      if (!in_valid || !in_stall) begin
        if (send_wait > 0) begin
          in_valid <= 1'b0;
          send_wait--;
        end else if (samples_todo.size() != 0) begin
          next_sample = samples_todo.pop_front();
          in_valid    <= 1'b1;
          in_range_mm <= next_sample.range_mm;
          in_scan_end <= next_sample.scan_end;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Point monitor: checks results and drives out_stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_wait = 0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got.point_valid  = out_point_valid;
        got.x_mm         = out_x_mm;
        got.y_mm         = out_y_mm;
        got.last_of_scan = out_last_of_scan;
        points_seen++;
        if (points_due.size() == 0) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("point %0d unexpected: pv=%0b x=%0d y=%0d last=%0b", points_seen,
                     got.point_valid, $signed(got.x_mm), $signed(got.y_mm),
                     got.last_of_scan);
        end else begin
          want = points_due.pop_front();
          if (got.point_valid !== want.point_valid || got.x_mm !== want.x_mm ||
              got.y_mm !== want.y_mm || got.last_of_scan !== want.last_of_scan) begin
            err_count++;
            if (err_count <= MAX_REPORTS)
              $display("point %0d: expected pv=%0b x=%0d y=%0d last=%0b, got pv=%0b x=%0d y=%0d last=%0b",
                       points_seen, want.point_valid, $signed(want.x_mm),
                       $signed(want.y_mm), want.last_of_scan, got.point_valid,
                       $signed(got.x_mm), $signed(got.y_mm), got.last_of_scan);
          end
        end
        recv_wait = $urandom_range(0, stall_max);
      end
      // long hold-off on request, otherwise the per-point wait
      if (hold_req != hold_served) begin
        hold_served = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (recv_wait > 0) begin
        out_stall <= 1'b1;
        recv_wait--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: too long without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Stimulus sequence
  initial begin
    logic [31:0] ra, rs;
    logic [15:0] rlo, rhi, r;
    int n, scan_len;

    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: angle 0, every range accepted
    queue_sample(16'h0000, 1'b0);
    queue_sample(16'hFFFF, 1'b0);
    queue_sample(16'h0001, 1'b1);

    // quarter-turn steps through all quadrants, wrap, then restart after scan end
    reprogram(32'h0000_0000, 32'h4000_0000, 16'h0000, 16'hFFFF);
    for (int k = 0; k < 5; k++) queue_sample(16'hFFFF, k == 4);
    queue_sample(16'd1000, 1'b0);
    queue_sample(16'h5555, 1'b1);

    // single accepted range, angles counting down from just below a full turn
    reprogram(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd100, 16'd100);
    queue_sample(16'd99, 1'b0);
    queue_sample(16'd100, 1'b0);
    queue_sample(16'd101, 1'b0);
    queue_sample(16'h0000, 1'b0);
    queue_sample(16'hFFFF, 1'b1);

    // straddle the first quadrant edge
    reprogram(32'h3FFF_FFFF, 32'h0000_0001, 16'h0000, 16'hFFFF);
    queue_sample(16'hFFFF, 1'b0);
    queue_sample(16'hFFFF, 1'b1);

    // min above max rejects everything; stray indexes must not land anywhere
    reprogram(32'hBFFF_FFFF, 32'h0000_0001, 16'hFFFF, 16'h0000);
    write_reg(REG_UNUSED_LO, 32'h1234_5678);
    write_reg(REG_UNUSED_HI, 32'hFFFF_FFFF);
    queue_sample(16'hFFFF, 1'b0);
    queue_sample(16'h0000, 1'b1);

    // full range on the diagonals
    reprogram(32'h2000_0000, 32'h4000_0000, 16'h0000, 16'hFFFF);
    for (int k = 0; k < 4; k++) queue_sample(16'hFFFF, k == 3);

    // random phases, each under its own setting and idling mode
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait_idle();
      case (ph % 4)
        0: begin gap_max = 4; stall_max = 4; end
        1: begin gap_max = 0; stall_max = 0; end
        2: begin gap_max = 0; stall_max = 4; end
        default: begin gap_max = 4; stall_max = 0; end
      endcase
      case ($urandom_range(0, 3))
        0: ra = 32'h0000_0000;
        1: ra = 32'hFFFF_FFFF;
        default: ra = $urandom();
      endcase
      case ($urandom_range(0, 4))
        0: rs = 32'h0000_0000;
        1: rs = 32'hFFFF_FFFF;
        2: rs = $urandom_range(0, 1 << 20);
        3: rs = 32'hFFFF_FFFF / $urandom_range(1, 720);
        default: rs = $urandom();
      endcase
      case ($urandom_range(0, 5))
        0: begin rlo = 16'h0000; rhi = 16'hFFFF; end
        1: begin rlo = 16'($urandom()); rhi = 16'($urandom()); end
        default: begin
          rlo = 16'($urandom_range(0, 3000));
          rhi = 16'($urandom_range(20000, 65535));
        end
      endcase
      reprogram(ra, rs, rlo, rhi);
      if ($urandom_range(0, 2) == 0)
        write_reg(8'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)), $urandom());

      // scans of random length, a stray scan end now and then
      n = 0;
      while (n < PHASE_ITEMS) begin
        scan_len = $urandom_range(1, 48);
        for (int k = 0; k < scan_len && n < PHASE_ITEMS; k++) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: r = 16'($urandom());
            5, 6: r = 16'(rlo + $urandom_range(0, 4) - 2);
            7, 8: r = 16'(rhi + $urandom_range(0, 4) - 2);
            default: r = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
          endcase
          queue_sample(r, (k == scan_len - 1) || ($urandom_range(0, 31) == 0));
          n++;
        end
      end
      // back up the result side while samples keep coming
      if (ph == 2) hold_req++;
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && points_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
